// ===== rtl/kpct_pkg.sv =====
// Shared types, constants and a helper function for the keyed pair counter table.
package kpct_pkg;

  // Field widths fixed by the transaction format.
  localparam int unsigned KEY_W   = 31;
  localparam int unsigned COUNT_W = 32;

  // One incoming transaction: a key and the side whose counter is bumped.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             side;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic [COUNT_W-1:0] count_side_zero;
    logic [COUNT_W-1:0] count_side_one;
    logic               was_inserted;
    logic               table_full;
  } result_t;

  // Transaction state as it travels from one cell to the next.
  typedef struct packed {
    logic               valid;
    logic               done;
    logic [KEY_W-1:0]   key;
    logic               side;
    logic               inserted;
    logic [COUNT_W-1:0] count_zero;
    logic [COUNT_W-1:0] count_one;
  } stage_t;

  // Increment that sticks at the all-ones value.
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (&v) ? v : v + {{(COUNT_W-1){1'b0}}, 1'b1};
    return r;
  endfunction

endpackage

// ===== rtl/kpct_cell.sv =====
// One table cell: holds a single keyed entry and forwards the passing transaction.
module kpct_cell (
  input  logic            clk,
  input  logic            rst,
  input  kpct_pkg::stage_t prev,
  output kpct_pkg::stage_t fwd
);

  logic                          occ;
  logic [kpct_pkg::KEY_W-1:0]    entry_key;
  logic [kpct_pkg::COUNT_W-1:0]  cnt0;
  logic [kpct_pkg::COUNT_W-1:0]  cnt1;
  logic [kpct_pkg::COUNT_W-1:0]  cnt0_next;
  logic [kpct_pkg::COUNT_W-1:0]  cnt1_next;
  kpct_pkg::stage_t              fwd_next;
  logic                          hit;
  logic                          claim;

  // A live transaction either matches this entry or, if the cell is still empty,
  // takes it over. Cells fill in order, so the first empty cell is the append slot.
  always_comb begin
    hit       = prev.valid && !prev.done && occ && (entry_key == prev.key);
    claim     = prev.valid && !prev.done && !occ;
    cnt0_next = cnt0;
    cnt1_next = cnt1;
    fwd_next  = prev;
    if (claim) begin
      cnt0_next         = prev.side ? '0 : {{(kpct_pkg::COUNT_W-1){1'b0}}, 1'b1};
      cnt1_next         = prev.side ? {{(kpct_pkg::COUNT_W-1){1'b0}}, 1'b1} : '0;
      fwd_next.inserted = 1'b1;
    end else if (hit) begin
      if (prev.side) begin
        cnt1_next = kpct_pkg::sat_inc(cnt1);
      end else begin
        cnt0_next = kpct_pkg::sat_inc(cnt0);
      end
    end
    if (hit || claim) begin
      fwd_next.done       = 1'b1;
      fwd_next.count_zero = cnt0_next;
      fwd_next.count_one  = cnt1_next;
    end
  end

  // Occupancy and the forwarding stage's valid bit are control; they clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= 1'b0;
      fwd.valid <= 1'b0;
    end else begin
      occ <= occ | claim;
      fwd <= fwd_next;
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    if (claim) begin
      entry_key <= prev.key;
    end
    cnt0 <= cnt0_next;
    cnt1 <= cnt1_next;
  end

`ifndef SYNTHESIS
  // An entry, once taken, is never released.
  a_occ_sticky: assert property (@(posedge clk) disable iff (rst) occ |=> occ)
    else $error("cell lost its entry");

  // A transaction that leaves unresolved has passed an occupied cell.
  a_unresolved_needs_occ: assert property (@(posedge clk) disable iff (rst)
    (fwd.valid && !fwd.done) |-> occ)
    else $error("unresolved transaction passed an empty cell");

  // A newly taken entry starts with exactly one count on one side.
  a_new_entry_counts: assert property (@(posedge clk) disable iff (rst)
    $rose(occ) |-> ((cnt0 == '0 && cnt1 == {{(kpct_pkg::COUNT_W-1){1'b0}}, 1'b1}) ||
                    (cnt1 == '0 && cnt0 == {{(kpct_pkg::COUNT_W-1){1'b0}}, 1'b1})))
    else $error("new entry has wrong counts");

  // An inserted flag is only ever carried by a resolved transaction.
  a_inserted_done: assert property (@(posedge clk) disable iff (rst)
    (fwd.valid && fwd.inserted) |-> fwd.done)
    else $error("inserted flag without resolution");
`endif

endmodule

// ===== rtl/keyed_pair_counter_table_top.sv =====
// Keyed pair counter table: a chain of entry cells that every transaction walks through.
// Throughput: one transaction per cycle; busy stays low, each cell sees one item per cycle.
// The latency is set by the length of the cell chain, each cell registering the transaction.
// Reset empties the table and discards transactions in flight; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module keyed_pair_counter_table_top #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  kpct_pkg::req_t    req,
  output logic              result_valid,
  output kpct_pkg::result_t result
);

  kpct_pkg::stage_t chain [ENTRIES+1];

  // The chain takes a new transaction every cycle.
  assign busy = 1'b0;

  // Launch a transaction into the head of the chain.
  always_comb begin
    chain[0].valid      = start && !busy;
    chain[0].done       = 1'b0;
    chain[0].key        = req.key;
    chain[0].side       = req.side;
    chain[0].inserted   = 1'b0;
    chain[0].count_zero = '0;
    chain[0].count_one  = '0;
  end

  // Row of cells, one per table entry.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kpct_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .prev (chain[i]),
      .fwd  (chain[i+1])
    );
  end

  // A transaction still unresolved at the tail found neither its key nor room.
  always_comb begin
    result_valid           = chain[ENTRIES].valid;
    result.count_side_zero = chain[ENTRIES].count_zero;
    result.count_side_one  = chain[ENTRIES].count_one;
    result.was_inserted    = chain[ENTRIES].inserted;
    result.table_full      = !chain[ENTRIES].done;
  end

endmodule

// ===== verif/tb_keyed_pair_counter_table_top.sv =====
// Self-checking testbench for the keyed pair counter table.
`timescale 1ns / 1ps

module tb_keyed_pair_counter_table_top;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned MAX_PRINTS   = 40;

  // Tracks the table contents and the results it implies, in arrival order.
  class count_scoreboard;
    logic [kpct_pkg::KEY_W-1:0]   keys  [ENTRIES];
    logic [kpct_pkg::COUNT_W-1:0] zeros [ENTRIES];
    logic [kpct_pkg::COUNT_W-1:0] ones  [ENTRIES];
    int unsigned                  used;
    kpct_pkg::result_t            expected_q[$];
    int unsigned                  errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    // Counters stick at all ones.
    function logic [kpct_pkg::COUNT_W-1:0] bump(input logic [kpct_pkg::COUNT_W-1:0] v);
      return (&v) ? v : v + {{(kpct_pkg::COUNT_W-1){1'b0}}, 1'b1};
    endfunction

    // Applies one accepted transaction to the table and queues its result.
    function void note(input kpct_pkg::req_t r);
      int                slot;
      bit                found;
      kpct_pkg::result_t want;
      slot  = 0;
      found = 1'b0;
      want  = '0;
      for (int i = 0; i < used; i++) begin
        if (!found && keys[i] == r.key) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (!found && used >= ENTRIES) begin
        // New key with no room left: dropped, only the full flag is set.
        want.table_full = 1'b1;
      end else begin
        if (!found) begin
          slot        = int'(used);
          keys[slot]  = r.key;
          zeros[slot] = '0;
          ones[slot]  = '0;
          used++;
          want.was_inserted = 1'b1;
        end
        if (r.side) begin
          ones[slot] = bump(ones[slot]);
        end else begin
          zeros[slot] = bump(zeros[slot]);
        end
        want.count_side_zero = zeros[slot];
        want.count_side_one  = ones[slot];
      end
      expected_q.push_back(want);
    endfunction

    task report(input string what, input logic [kpct_pkg::COUNT_W-1:0] got,
                input logic [kpct_pkg::COUNT_W-1:0] want);
      errors++;
      if (errors <= MAX_PRINTS) begin
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      end
    endtask

    // Compares one result transaction with the oldest expectation.
    task check(input kpct_pkg::result_t got);
      kpct_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result, count_side_zero", got.count_side_zero, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.count_side_zero !== want.count_side_zero) begin
        report("count_side_zero", got.count_side_zero, want.count_side_zero);
      end
      if (got.count_side_one !== want.count_side_one) begin
        report("count_side_one", got.count_side_one, want.count_side_one);
      end
      if (got.was_inserted !== want.was_inserted) begin
        report("was_inserted", {{(kpct_pkg::COUNT_W-1){1'b0}}, got.was_inserted},
               {{(kpct_pkg::COUNT_W-1){1'b0}}, want.was_inserted});
      end
      if (got.table_full !== want.table_full) begin
        report("table_full", {{(kpct_pkg::COUNT_W-1){1'b0}}, got.table_full},
               {{(kpct_pkg::COUNT_W-1){1'b0}}, want.table_full});
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  kpct_pkg::req_t    req;
  logic              result_valid;
  kpct_pkg::result_t result;

  count_scoreboard            sb;
  logic [kpct_pkg::KEY_W-1:0] key_pool[$];
  logic [kpct_pkg::KEY_W-1:0] last_key;
  int unsigned                cycles = 0;

  keyed_pair_counter_table_top #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .result_valid(result_valid),
    .result      (result)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watch both handshakes on every edge; values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note(req);
      end
      if (result_valid) begin
        sb.check(result);
      end
    end
  end

  // Hard stop in case the block hangs or loses results.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Holds one transaction on the inputs until the block takes it.
  task automatic send(input logic [kpct_pkg::KEY_W-1:0] k, input logic s);
    kpct_pkg::req_t r;
    r.key  = k;
    r.side = s;
    start <= 1'b1;
    req   <= r;
    last_key = k;
    do @(posedge clk); while (busy);
  endtask

  // Idle gap with junk on the payload, which the block must ignore.
  task automatic idle(input int unsigned n);
    logic [31:0] junk;
    if (n > 0) begin
      junk = $urandom;
      start <= 1'b0;
      req   <= junk;
      repeat (n) @(posedge clk);
    end
  endtask

  // Mostly keys already seen, so hits dominate; new keys fill the table and
  // then exercise the full case. Repeats of the last key hit back to back.
  function automatic logic [kpct_pkg::KEY_W-1:0] pick_key();
    int unsigned                roll;
    logic [31:0]                raw;
    logic [kpct_pkg::KEY_W-1:0] k;
    roll = $urandom_range(0, 99);
    if (key_pool.size() > 0 && roll < 15) begin
      k = last_key;
    end else if (key_pool.size() > 0 && roll < 70) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else begin
      raw = $urandom;
      case ($urandom_range(0, 9))
        0: k = '0;
        1: k = '1;
        default: k = raw[kpct_pkg::KEY_W-1:0];
      endcase
      key_pool.push_back(k);
    end
    return k;
  endfunction

  initial begin
    int unsigned                sent;
    int unsigned                burst;
    logic [kpct_pkg::KEY_W-1:0] directed_keys[$];
    logic                       directed_sides[$];

    sb = new();
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    last_key = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: key extremes, both sides, alternating bit patterns, and the
    // same key in consecutive cycles.
    directed_keys  = '{31'h0, 31'h0, 31'h0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
                       31'h55555555, 31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA,
                       31'h1, 31'h40000000, 31'h0, 31'h7FFFFFFF, 31'h1, 31'h40000000};
    directed_sides = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
                       1'b0, 1'b1, 1'b1, 1'b0,
                       1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    foreach (directed_keys[i]) begin
      send(directed_keys[i], directed_sides[i]);
      key_pool.push_back(directed_keys[i]);
      if (i == 9) begin
        idle(3);
      end
    end

    // Random: bursts of random length with random gaps; the first stretch
    // runs without gaps to keep the chain full.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        send(pick_key(), 1'($urandom_range(0, 1)));
        sent++;
      end
      if (sent >= 120 && $urandom_range(0, 3) != 0) begin
        idle($urandom_range(1, 8));
      end
    end
    start <= 1'b0;

    // Drain, then wait longer than a chain length for anything stray.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 16) @(posedge clk);

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
